### hdl/dtd_pkg.sv
// shared types, constants and helpers of the double to decimal text formatter
package dtd_pkg;

	localparam int MAX_DEC_DEF = 10;
	localparam int MANT_W      = 53;
	localparam int EXP_W       = 12;
	localparam int MAG_W       = 64;
	localparam int MAG_DIGITS  = 19;
	localparam int BCD_W       = 4 * MAG_DIGITS;
	localparam int POS_W       = 7;
	localparam int MAX_OUT     = 32;
	localparam int VAL_W       = 64;
	localparam int PREC_IN_W   = 8;
	localparam int LIM_W       = 7;
	localparam int CHAR_W      = 8;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

	localparam logic [MANT_W-1:0] MANT_ONE = {1'b1, 52'd0};
	localparam logic [10:0] EXP_ALL1 = 11'h7FF;

	localparam logic [MAG_W-1:0] POW10_T [0:MAG_DIGITS] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
		64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
		64'd100000000000, 64'd1000000000000, 64'd10000000000000,
		64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
		64'd100000000000000000, 64'd1000000000000000000,
		64'd10000000000000000000
	};

	typedef struct packed {
		logic [MANT_W-1:0] mant;
		logic              carry;
	} dtd_rnd_t;

	typedef struct packed {
		logic load;
		logic step;
	} dtd_bcd_ctl_t;

	function automatic logic signed [EXP_W-1:0] exp_of(input logic [VAL_W-1:0] bits);
		return $signed({1'b0, bits[62:52]}) - 12'sd1023;
	endfunction

	function automatic logic [MANT_W-1:0] mant_of(input logic [VAL_W-1:0] bits);
		return {1'b1, bits[51:0]};
	endfunction

	function automatic logic [MAG_W-1:0] trunc_mag(input logic [MANT_W-1:0] m,
			input logic signed [EXP_W-1:0] e);
		logic [MAG_W-1:0] wide;
		logic [5:0] sh;
		wide = {11'd0, m};
		sh = '0;
		if (e < 0) begin
			return '0;
		end else if (e > 12'sd63) begin
			return '0;
		end else if (e >= 12'sd52) begin
			sh = e[5:0] - 6'd52;
			return wide << sh;
		end else begin
			sh = 6'd52 - e[5:0];
			return wide >> sh;
		end
	endfunction

endpackage

### hdl/dtd_in_if.sv
// number channel: binary64 value, precision and digit limit
interface dtd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	logic [7:0]  precision;
	logic [6:0]  digit_limit;
	modport source (output valid, value_bits, precision, digit_limit, input ready);
	modport sink (input valid, value_bits, precision, digit_limit, output ready);
endinterface

### hdl/dtd_out_if.sv
// text channel: one ascii character per transfer
interface dtd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;
	logic       overflow;
	modport source (output valid, char_code, last, overflow, input ready);
	modport sink (input valid, char_code, last, overflow, output ready);
endinterface

### hdl/dtd_mul10.sv
// shared exact multiply by ten of the wide mantissa accumulator
module dtd_mul10 #(
	parameter int ACC_W = 87
) (
	input  logic [ACC_W-1:0] acc,
	output logic [ACC_W+3:0] prod
);
	import dtd_pkg::*;

	logic [ACC_W+3:0] ext;

	assign ext  = {4'd0, acc};
	assign prod = (ext << 3) + (ext << 1);
endmodule

### hdl/dtd_round.sv
// round the accumulator to 53 bits, nearest even, below its leading one
module dtd_round #(
	parameter int ACC_W = 87,
	parameter int TW    = 7
) (
	input  logic [ACC_W-1:0]  acc,
	input  logic [TW-1:0]     top,
	output dtd_pkg::dtd_rnd_t rnd
);
	import dtd_pkg::*;

	logic [TW-1:0]     sh;
	logic [ACC_W-1:0]  norm;
	logic [MANT_W-1:0] mant;
	logic              guard;
	logic              sticky;
	logic              inc;
	logic [MANT_W:0]   sum;

	always_comb begin
		sh     = TW'(ACC_W - 1) - top;
		norm   = acc << sh;
		mant   = norm[ACC_W-1 -: MANT_W];
		guard  = norm[ACC_W-1-MANT_W];
		sticky = |norm[ACC_W-2-MANT_W:0];
		inc    = guard & (sticky | mant[0]);
		sum    = {1'b0, mant} + {{MANT_W{1'b0}}, inc};
		rnd.carry = sum[MANT_W];
		rnd.mant  = sum[MANT_W] ? sum[MANT_W:1] : sum[MANT_W-1:0];
	end
endmodule

### hdl/dtd_bcd.sv
// binary to bcd converter, one shift and correct step per cycle while ctl.step is set
module dtd_bcd (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dtd_pkg::dtd_bcd_ctl_t        ctl,
	input  logic [dtd_pkg::MAG_W-1:0]    bin,
	output logic [dtd_pkg::BCD_W-1:0]    bcd
);
	import dtd_pkg::*;

	logic [MAG_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int q = 0; q < MAG_DIGITS; q++) begin
			adj[4*q +: 4] = (bcd_q[4*q +: 4] >= 4'd5) ? bcd_q[4*q +: 4] + 4'd3
				: bcd_q[4*q +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (ctl.load) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[BCD_W-2:0], bin_q[MAG_W-1]};
		end
	end

	assign bcd = bcd_q;
endmodule

### hdl/double_to_decimal_text.sv
// double to decimal text formatter, top level and sequencer
// usage: a number goes in on num (binary64 bits, precision, digit limit); its text
// comes out on txt, one ascii character per transfer, last set on the final one.
// nan, infinity and values whose scaled form leaves the signed 64-bit range give a
// single transfer with char_code 0, last and overflow set.
// sequence: for a positive value the decimal count search first runs up to
// MAX_DECIMALS iterations of the shared times-ten unit; the scaling then takes up
// to MAX_DECIMALS steps on the same unit plus one rounding step, followed by the
// binary to decimal conversion and the layout, then one character per cycle while
// txt.ready does not hold it back, at most 32 characters.
// throughput: one number at a time; num.ready is high only between numbers,
// and a new number may enter while the last character still waits on txt.
// reset clears the sequencer and the output valid; nothing is in flight.
// when txt.ready is low with a valid character, that character holds and emission waits.
module double_to_decimal_text #(
	parameter int MAX_DECIMALS = dtd_pkg::MAX_DEC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dtd_in_if.sink     num,
	dtd_out_if.source  txt
);
	import dtd_pkg::*;

	localparam int PW    = (MAX_DECIMALS * 3322) / 1000 + 1;
	localparam int ACC_W = MANT_W + PW;
	localparam int TW    = $clog2(ACC_W + 4);
	localparam int KW    = $clog2(MAX_DECIMALS + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_KCHK   = 4'd1;
	localparam logic [3:0] ST_MUL    = 4'd2;
	localparam logic [3:0] ST_ROUND  = 4'd3;
	localparam logic [3:0] ST_TRUNC  = 4'd4;
	localparam logic [3:0] ST_BCD    = 4'd5;
	localparam logic [3:0] ST_LEN    = 4'd6;
	localparam logic [3:0] ST_LAYOUT = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;

	logic [3:0] state_q;

	logic [VAL_W-1:0]        x_q;
	logic [KW-1:0]           prec_q;
	logic [LIM_W-1:0]        lim_q;
	logic                    neg_q;
	logic                    tiny_q;
	logic                    zero_q;
	logic                    ovft_q;
	logic                    phase_q;
	logic [MANT_W-1:0]       m_q;
	logic signed [EXP_W-1:0] e_q;
	logic [KW-1:0]           k_q;
	logic [KW-1:0]           dec_q;
	logic [KW-1:0]           steps_q;
	logic [ACC_W-1:0]        acc_q;
	logic [TW-1:0]           t_q;
	logic [MAG_W-1:0]        wmag_q;
	logic [4:0]              wlen_q;
	logic [6:0]              cnt_q;
	logic [4:0]              ilen_q;
	logic                    casea_q;
	logic                    sgn_q;
	logic [POS_W-1:0]        wl_q;
	logic [POS_W-1:0]        fl_q;
	logic [POS_W-1:0]        z_q;
	logic [POS_W-1:0]        n_q;
	logic [POS_W-1:0]        p_q;

	logic              out_v_q;
	logic [CHAR_W-1:0] out_c_q;
	logic              out_l_q;
	logic              out_o_q;

	// shared arithmetic
	logic [ACC_W+3:0] prod;
	dtd_rnd_t         rnd;
	logic [TW-1:0]    t4;
	logic [TW-1:0]    t_next;

	dtd_mul10 #(.ACC_W(ACC_W)) u_mul10 (.acc(acc_q), .prod(prod));
	dtd_round #(.ACC_W(ACC_W), .TW(TW)) u_round (.acc(acc_q), .top(t_q), .rnd(rnd));

	assign t4     = t_q + TW'(4);
	assign t_next = prod[t4] ? t4 : t_q + TW'(3);

	// binary to decimal
	dtd_bcd_ctl_t     bctl;
	logic [MAG_W-1:0] mag;
	logic [BCD_W-1:0] bcd;

	dtd_bcd u_bcd (.clk(clk), .arst_n(arst_n), .ctl(bctl), .bin(mag), .bcd(bcd));

	// input decode
	logic                    in_xfer;
	logic [10:0]             in_bexp;
	logic                    in_special;
	logic                    in_zero;
	logic                    in_tiny;
	logic [KW-1:0]           in_prec;

	assign in_xfer    = num.valid && num.ready;
	assign in_bexp    = num.value_bits[62:52];
	assign in_special = (in_bexp == EXP_ALL1);
	assign in_zero    = (num.value_bits[62:0] == 63'd0);
	assign in_tiny    = (in_bexp == 11'd0) && !in_zero;
	assign in_prec    = (num.precision > PREC_IN_W'(MAX_DECIMALS)) ? KW'(MAX_DECIMALS)
		: KW'(num.precision);

	// whole-number test of the search value
	logic [5:0]        wsh;
	logic [MANT_W-1:0] wmask;
	logic              whole;
	logic              kstop;

	always_comb begin
		wsh   = 6'd52 - e_q[5:0];
		wmask = (MANT_W'(1) << wsh) - MANT_W'(1);
		if (e_q >= 12'sd52) begin
			whole = 1'b1;
		end else begin
			whole = ((m_q & wmask) == '0);
		end
		kstop = (k_q == KW'(MAX_DECIMALS)) || (!e_q[EXP_W-1] && whole);
	end

	// truncation and range check of the scaled value
	logic ovf;

	always_comb begin
		ovf = !tiny_q && !e_q[EXP_W-1] && ((e_q > 12'sd63) ||
			((e_q == 12'sd63) && !(neg_q && (m_q == MANT_ONE))));
		mag = tiny_q ? '0 : trunc_mag(m_q, e_q);
	end

	// digit masks and layout
	logic [MAG_DIGITS-1:0] nz;
	logic [4:0]            ilen_c;
	logic [POS_W-1:0]      ilen7;
	logic [POS_W-1:0]      wlen7;
	logic [POS_W-1:0]      lim_m1;
	logic [POS_W-1:0]      leff;
	logic [POS_W-1:0]      qmin;
	logic                  has;
	logic [4:0]            qf;
	logic [POS_W-1:0]      ilast;
	logic                  casea;
	logic [POS_W-1:0]      zc;
	logic [POS_W-1:0]      wl_c;
	logic [POS_W-1:0]      fl_c;
	logic                  pt_c;
	logic [POS_W-1:0]      fln_c;
	logic                  sgn_c;
	logic [POS_W-1:0]      n_c;

	always_comb begin
		for (int q = 0; q < MAG_DIGITS; q++) begin
			nz[q] = |bcd[4*q +: 4];
		end
		ilen_c = 5'd1;
		for (int q = 0; q < MAG_DIGITS; q++) begin
			if (nz[q]) begin
				ilen_c = 5'(q + 1);
			end
		end
	end

	always_comb begin
		ilen7  = POS_W'(ilen_q);
		wlen7  = POS_W'(wlen_q);
		lim_m1 = lim_q - 7'd1;
		if (zero_q || lim_q == 7'd0) begin
			leff = '0;
		end else if (lim_m1 < ilen7) begin
			leff = lim_m1;
		end else begin
			leff = ilen7;
		end
		qmin = ilen7 - leff;
		has  = 1'b0;
		qf   = '0;
		for (int q = MAG_DIGITS - 1; q >= 0; q--) begin
			if (nz[q] && (POS_W'(q) >= qmin)) begin
				has = 1'b1;
				qf  = 5'(q);
			end
		end
		ilast = ilen7 - 7'd1 - POS_W'(qf);
		casea = (wmag_q == '0);
		if (casea && !zero_q && (POS_W'(dec_q) > ilen7)) begin
			zc = POS_W'(dec_q) - ilen7;
		end else begin
			zc = '0;
		end
		if (casea) begin
			wl_c = 7'd1;
			fl_c = has ? zc + ilast + 7'd1 : '0;
		end else if (leff >= wlen7) begin
			wl_c = wlen7;
			fl_c = (has && ilast >= wlen7) ? ilast + 7'd1 - wlen7 : '0;
		end else begin
			wl_c = has ? ilast + 7'd1 : '0;
			fl_c = '0;
		end
		if (prec_q != '0) begin
			pt_c  = 1'b1;
			fln_c = POS_W'(prec_q);
		end else begin
			pt_c  = (fl_c != '0);
			fln_c = fl_c;
		end
		sgn_c = neg_q && !zero_q;
		n_c   = POS_W'(sgn_c) + wl_c + (pt_c ? fln_c + 7'd1 : 7'd0);
		if (n_c > POS_W'(MAX_OUT)) begin
			n_c = POS_W'(MAX_OUT);
		end
	end

	// character at the current position
	logic [POS_W-1:0]  w;
	logic [POS_W-1:0]  j;
	logic [POS_W-1:0]  di;
	logic [4:0]        dq;
	logic [3:0]        nib;
	logic              use_dig;
	logic [CHAR_W-1:0] chr;

	always_comb begin
		w       = p_q - POS_W'(sgn_q);
		j       = w - wl_q - 7'd1;
		di      = '0;
		use_dig = 1'b0;
		chr     = CH_ZERO;
		if (ovft_q) begin
			chr = CH_NONE;
		end else if (sgn_q && p_q == '0) begin
			chr = CH_MINUS;
		end else if (w < wl_q) begin
			use_dig = !casea_q;
			di      = w;
		end else if (w == wl_q) begin
			chr = CH_DOT;
		end else if (j < fl_q) begin
			if (casea_q) begin
				use_dig = (j >= z_q);
				di      = j - z_q;
			end else begin
				use_dig = 1'b1;
				di      = wlen7 + j;
			end
		end
		dq  = ilen_q - 5'd1 - di[4:0];
		nib = bcd[4*dq +: 4];
		if (use_dig) begin
			chr = {4'h3, nib};
		end
	end

	logic out_free;
	assign out_free = !out_v_q || txt.ready;

	always_comb begin
		bctl.load = (state_q == ST_TRUNC);
		bctl.step = (state_q == ST_BCD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovft_q  <= 1'b0;
			p_q     <= '0;
			n_q     <= '0;
			k_q     <= '0;
			steps_q <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						x_q     <= num.value_bits;
						prec_q  <= in_prec;
						lim_q   <= num.digit_limit;
						neg_q   <= num.value_bits[63];
						zero_q  <= in_zero;
						tiny_q  <= in_zero || in_tiny;
						ovft_q  <= in_special;
						dec_q   <= KW'(MAX_DECIMALS);
						m_q     <= mant_of(num.value_bits);
						e_q     <= exp_of(num.value_bits);
						k_q     <= '0;
						acc_q   <= ACC_W'(mant_of(num.value_bits));
						t_q     <= TW'(52);
						steps_q <= KW'(MAX_DECIMALS);
						phase_q <= 1'b1;
						if (in_special) begin
							n_q     <= 7'd1;
							p_q     <= '0;
							state_q <= ST_EMIT;
						end else if (in_zero || in_tiny) begin
							state_q <= ST_TRUNC;
						end else if (num.value_bits[63]) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_KCHK;
						end
					end
				end
				ST_KCHK: begin
					t_q <= TW'(52);
					if (kstop) begin
						dec_q   <= (k_q == KW'(MAX_DECIMALS)) ? k_q : k_q + KW'(1);
						steps_q <= (k_q == KW'(MAX_DECIMALS)) ? k_q : k_q + KW'(1);
						acc_q   <= ACC_W'(mant_of(x_q));
						e_q     <= exp_of(x_q);
						phase_q <= 1'b1;
					end else begin
						steps_q <= KW'(1);
						acc_q   <= ACC_W'(m_q);
						phase_q <= 1'b0;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q   <= prod[ACC_W-1:0];
					t_q     <= t_next;
					steps_q <= steps_q - KW'(1);
					if (steps_q == KW'(1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					m_q <= rnd.mant;
					e_q <= e_q + EXP_W'(t_q) - EXP_W'(52) + EXP_W'(rnd.carry);
					if (phase_q) begin
						state_q <= ST_TRUNC;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= ST_KCHK;
					end
				end
				ST_TRUNC: begin
					wmag_q <= tiny_q ? '0 : trunc_mag(mant_of(x_q), exp_of(x_q));
					wlen_q <= 5'd1;
					cnt_q  <= '0;
					if (ovf) begin
						ovft_q  <= 1'b1;
						n_q     <= 7'd1;
						p_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_BCD;
					end
				end
				ST_BCD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q < 7'(MAG_DIGITS)) begin
						if (wmag_q >= POW10_T[cnt_q[4:0] + 5'd1]) begin
							wlen_q <= cnt_q[4:0] + 5'd2;
						end
					end
					if (cnt_q == 7'(MAG_W - 1)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					ilen_q  <= ilen_c;
					state_q <= ST_LAYOUT;
				end
				ST_LAYOUT: begin
					casea_q <= casea;
					sgn_q   <= sgn_c;
					wl_q    <= wl_c;
					fl_q    <= fl_c;
					z_q     <= zc;
					n_q     <= n_c;
					p_q     <= '0;
					state_q <= (n_c == '0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						p_q <= p_q + 7'd1;
						if (p_q == n_q - 7'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT) begin
			out_c_q <= chr;
			out_l_q <= (p_q == n_q - 7'd1);
			out_o_q <= ovft_q;
		end
	end

	assign num.ready     = (state_q == ST_IDLE);
	assign txt.valid     = out_v_q;
	assign txt.char_code = out_c_q;
	assign txt.last      = out_l_q;
	assign txt.overflow  = out_o_q;

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_o_q |-> out_l_q)
		else $error("flagged transfer without last");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> p_q < n_q && n_q <= 7'(MAX_OUT))
		else $error("character position out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != ST_IDLE)
		else $error("number taken but sequencer idle");

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> steps_q != '0)
		else $error("multiply step count empty");
endmodule
